/* sv/prfr_pkg.sv */
// shared types and codes for the response frame receiver
package prfr_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [8:0] len_t;
  typedef logic [1:0] fill_t;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_TIMEOUT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    EV_REQ     = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_STATUS  = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_END = 2'd1,
    ST_FCS_ERR = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic {
    CFG_END_BYTE = 1'b0,
    CFG_ACK_BYTE = 1'b1
  } cfg_idx_e;

  localparam byte_t EndByteReset = 8'h16;
  localparam byte_t AckByteReset = 8'hE5;
  localparam len_t  LenOverhead  = 9'd6;
  localparam len_t  HdrBytes     = 9'd4;
  localparam len_t  TrailBytes   = 9'd2;
  localparam fill_t WinFull      = 2'd3;

endpackage

/* sv/prfr_if.sv */
// word channels: received byte or timeout tick in, result word out
interface prfr_in_if import prfr_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  kind;
  byte_t rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface prfr_out_if import prfr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  byte_t      payload_byte;
  logic       toggle_bit;
  logic [1:0] status;
  len_t       frame_length;
  logic       last;

  modport source (output valid, output event_res, output payload_byte, output toggle_bit,
                  output status, output frame_length, output last, input ready);
  modport sink (input valid, input event_res, input payload_byte, input toggle_bit,
                input status, input frame_length, input last, output ready);
endinterface

/* sv/ppi_response_frame_receiver.sv */
// variable-length response frame receiver
//
// rx_i takes one word per cycle: a received byte (kind 0) or a receive
// timeout tick (kind 1). res_o gives at most one result word per input word:
// a request-data event with its toggle bit (acknowledge byte while hunting),
// a payload byte, or a status word: frame end with the frame length, or timeout.
// A result is registered and is on res_o in the cycle after its input word is taken.
// Throughput: one input word per cycle, set by the single output register;
// rx_i.ready is high whenever that register is empty or being read out.
// When the receiver stalls res_o, the pending result holds and rx_i.ready
// drops until it is taken.
// Reset: hunting for a header with an empty window, request toggle at 1,
// end byte 0x16 and acknowledge byte 0xE5; the output register is empty.
// cfg_we_i writes cfg_wdata_i to the register cfg_idx_i selects (0 end byte,
// 1 acknowledge byte) and is meant for idle periods only.
module ppi_response_frame_receiver import prfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  byte_t      cfg_wdata_i,
  prfr_in_if.sink    rx_i,
  prfr_out_if.source res_o
);

  byte_t end_byte_q, ack_byte_q;

  byte_t win_q [3];
  byte_t win_d [3];
  fill_t fill_q, fill_d;
  logic  in_frame_q, in_frame_d;
  len_t  total_q, total_d;
  len_t  pos_q, pos_d;
  byte_t sum_q, sum_d;
  byte_t fcs_q, fcs_d;
  logic  toggle_q, toggle_d;

  logic    out_valid_q;
  event_e  ev_q, ev_d;
  byte_t   pay_q, pay_d;
  logic    tog_q, tog_d;
  status_e st_q, st_d;
  len_t    len_q, len_d;
  logic    has_res;
  logic    in_fire;
  byte_t   b;

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign in_fire    = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_byte_q <= EndByteReset;
      ack_byte_q <= AckByteReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_END_BYTE: end_byte_q <= cfg_wdata_i;
        CFG_ACK_BYTE: ack_byte_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    win_d      = win_q;
    fill_d     = fill_q;
    in_frame_d = in_frame_q;
    total_d    = total_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    fcs_d      = fcs_q;
    toggle_d   = toggle_q;
    has_res    = 1'b0;
    ev_d       = EV_REQ;
    pay_d      = '0;
    tog_d      = 1'b0;
    st_d       = ST_OK;
    len_d      = '0;

    if (kind_e'(rx_i.kind) == KIND_TIMEOUT) begin
      has_res = 1'b1;
      ev_d    = EV_STATUS;
      st_d    = ST_TIMEOUT;
    end else if (!in_frame_q) begin
      if (b == ack_byte_q) begin
        has_res  = 1'b1;
        ev_d     = EV_REQ;
        tog_d    = toggle_q;
        toggle_d = !toggle_q;
        fill_d   = '0;
        win_d    = '{default: '0};
      end else if (fill_q != WinFull) begin
        win_d[fill_q] = b;
        fill_d        = fill_q + fill_t'(1);
      end else if (win_q[0] == b && win_q[1] == win_q[2]) begin
        in_frame_d = 1'b1;
        total_d    = {1'b0, win_q[1]} + LenOverhead;
        pos_d      = HdrBytes;
        sum_d      = '0;
        fcs_d      = '0;
      end else begin
        // slide the header window
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = b;
      end
    end else if (pos_q + TrailBytes < total_q) begin
      has_res = 1'b1;
      ev_d    = EV_PAYLOAD;
      pay_d   = b;
      sum_d   = sum_q + b;
      pos_d   = pos_q + len_t'(1);
    end else if (pos_q + TrailBytes == total_q) begin
      fcs_d = b;
      pos_d = pos_q + len_t'(1);
    end else begin
      has_res = 1'b1;
      ev_d    = EV_STATUS;
      len_d   = total_q;
      priority if (b != end_byte_q) st_d = ST_BAD_END;
      else if (fcs_q != sum_q)      st_d = ST_FCS_ERR;
      else                          st_d = ST_OK;
    end

    // any status word sends the block back to hunting
    if (has_res && ev_d == EV_STATUS) begin
      in_frame_d = 1'b0;
      fill_d     = '0;
      win_d      = '{default: '0};
      total_d    = '0;
      pos_d      = '0;
      sum_d      = '0;
      fcs_d      = '0;
      toggle_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '{default: '0};
      fill_q     <= '0;
      in_frame_q <= 1'b0;
      total_q    <= '0;
      pos_q      <= '0;
      sum_q      <= '0;
      fcs_q      <= '0;
      toggle_q   <= 1'b1;
    end else if (in_fire) begin
      win_q      <= win_d;
      fill_q     <= fill_d;
      in_frame_q <= in_frame_d;
      total_q    <= total_d;
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      fcs_q      <= fcs_d;
      toggle_q   <= toggle_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= has_res;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && has_res) begin
      ev_q  <= ev_d;
      pay_q <= pay_d;
      tog_q <= tog_d;
      st_q  <= st_d;
      len_q <= len_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.event_res    = ev_q;
  assign res_o.payload_byte = pay_q;
  assign res_o.toggle_bit   = tog_q;
  assign res_o.status       = st_q;
  assign res_o.frame_length = len_q;
  assign res_o.last         = (ev_q == EV_STATUS);

  // inside a frame the position stays between the header and the end byte
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> (pos_q >= HdrBytes && pos_q < total_q))
    else $error("byte position out of frame");

  // a status word leaves the block hunting with the toggle set
  a_status_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && has_res && ev_d == EV_STATUS) |=> (!in_frame_q && toggle_q && fill_q == '0))
    else $error("no return to hunting after status");

  // each request-data event flips the toggle
  a_req_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && has_res && ev_d == EV_REQ) |=> (toggle_q != $past(toggle_q)))
    else $error("request toggle did not flip");

  // a request-data event only comes while hunting
  a_req_hunting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && has_res && ev_d == EV_REQ) |-> !in_frame_q)
    else $error("request event inside a frame");

endmodule
